// ===== src/lcd_pkg.sv =====
package lcd_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int SP_W       = $clog2(SLOT_COUNT + 1);
  localparam int EDGE_W     = 2 * SLOT_W;
  localparam int THR_W      = 8;
  localparam int PC_W       = 64;

  typedef enum logic [1:0] {
    STATUS_ADDED   = 2'd0,
    STATUS_PRESENT = 2'd1,
    STATUS_SELF    = 2'd2,
    STATUS_CYCLE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_WRITE,
    ST_EMIT_RD,
    ST_EMIT_OUT,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] idx;
  } prio_t;

endpackage

// ===== src/lcd_prio.sv =====
module lcd_prio
  import lcd_pkg::*;
(
  input  logic [SLOT_COUNT-1:0] req_i,
  output prio_t                 res_o
);

  // lowest set bit wins
  always_comb begin
    res_o.hit = |req_i;
    res_o.idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (req_i[i]) begin
        res_o.idx = SLOT_W'(i);
      end
    end
  end

endmodule

// ===== src/lock_order_cycle_detector.sv =====
// the check reads the source row of the adjacency memory, then each search step
// (push or pop) of the depth-first search is bound by one read of the adjacency
// memory; a cycle report then reads the edge info memory once per chain slot
// one edge at a time: the input stalls until the last result beat is registered
// reset clears the adjacency rows at once through per-row valid bits
// the edge info memory holds no reset and is only read for stored edges
module lock_order_cycle_detector
  import lcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [4:0]        from_slot_i,
  input  logic [4:0]        to_slot_i,
  input  logic [7:0]        thread_index_i,
  input  logic [63:0]       acquire_pc_i,
  input  logic [5:0]        slots_in_use_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [4:0]        chain_slot_o,
  output logic [7:0]        hop_thread_o,
  output logic [63:0]       hop_pc_o,
  output logic              last_o
);

  localparam int INFO_W = THR_W + PC_W;

  state_e state_q, state_d;
  logic [SLOT_W-1:0]     from_q, from_d, to_q, to_d;
  logic [THR_W-1:0]      thr_q, thr_d;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [SLOT_COUNT-1:0] mask_q, mask_d, from_row_q, from_row_d, vis_q, vis_d;
  logic                  found_q, found_d;
  logic [SP_W-1:0]       sp_q, sp_d;
  logic [SLOT_W-1:0]     k_q, k_d;
  logic [SLOT_W-1:0]     stk_q [SLOT_COUNT];
  logic                  push;
  logic [SLOT_W-1:0]     push_val;

  logic                  ov_q, ov_d, olast_q, olast_d;
  status_e               ostat_q, ostat_d;
  logic [SLOT_W-1:0]     oslot_q, oslot_d;
  logic [THR_W-1:0]      othr_q, othr_d;
  logic [PC_W-1:0]       opc_q, opc_d;
  logic                  out_free;

  // adjacency memory
  logic [SLOT_COUNT-1:0] adj_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] adj_vld_q;
  logic [SLOT_COUNT-1:0] adj_rdata_q, adj_wd, row;
  logic                  adj_rvld_q, adj_re, adj_we;
  logic [SLOT_W-1:0]     adj_ra;

  // edge info memory
  logic [INFO_W-1:0]     edge_mem [SLOT_COUNT * SLOT_COUNT];
  logic [INFO_W-1:0]     edge_rdata_q;
  logic                  edge_re, edge_we;
  logic [EDGE_W-1:0]     edge_ra;

  logic [SLOT_COUNT-1:0] cand;
  prio_t                 pick;
  logic [6:0]            lim;
  logic [SLOT_W-1:0]     top_idx, below_idx;

  always_ff @(posedge clk_i) begin
    if (adj_we) adj_mem[from_q] <= adj_wd;
    if (adj_re) adj_rdata_q <= adj_mem[adj_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_vld_q  <= '0;
      adj_rvld_q <= 1'b0;
    end else begin
      if (adj_we) adj_vld_q[from_q] <= 1'b1;
      if (adj_re) adj_rvld_q <= adj_vld_q[adj_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[{from_q, to_q}] <= {thr_q, pc_q};
    if (edge_re) edge_rdata_q <= edge_mem[edge_ra];
  end

  assign row  = adj_rvld_q ? adj_rdata_q : '0;
  assign cand = row & ~vis_q & mask_q;
  assign adj_wd = from_row_q | (SLOT_COUNT'(1) << to_q);
  assign out_free = !ov_q || !out_stall_i;
  assign top_idx   = SLOT_W'(sp_q - SP_W'(1));
  assign below_idx = SLOT_W'(sp_q - SP_W'(2));

  lcd_prio u_prio (
    .req_i (cand),
    .res_o (pick)
  );

  always_ff @(posedge clk_i) begin
    if (push) stk_q[sp_q[SLOT_W-1:0]] <= push_val;
  end

  always_comb begin
    state_d    = state_q;
    from_d     = from_q;
    to_d       = to_q;
    thr_d      = thr_q;
    pc_d       = pc_q;
    mask_d     = mask_q;
    from_row_d = from_row_q;
    vis_d      = vis_q;
    found_d    = found_q;
    sp_d       = sp_q;
    k_d        = k_q;
    push       = 1'b0;
    push_val   = '0;
    ov_d       = ov_q && out_stall_i;
    ostat_d    = ostat_q;
    oslot_d    = oslot_q;
    othr_d     = othr_q;
    opc_d      = opc_q;
    olast_d    = olast_q;
    adj_re     = 1'b0;
    adj_ra     = from_q;
    adj_we     = 1'b0;
    edge_re    = 1'b0;
    edge_ra    = '0;
    edge_we    = 1'b0;
    in_stall_o = 1'b1;
    lim        = (slots_in_use_i > 6'(SLOT_COUNT)) ? 7'(SLOT_COUNT) : 7'(slots_in_use_i);

    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          from_d  = from_slot_i;
          to_d    = to_slot_i;
          thr_d   = thread_index_i;
          pc_d    = acquire_pc_i;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            mask_d[i] = 7'(i) < lim;
          end
          adj_re  = 1'b1;
          adj_ra  = from_slot_i;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        from_row_d = row;
        if (from_q == to_q || row[to_q]) begin
          if (out_free) begin
            ov_d    = 1'b1;
            ostat_d = (from_q == to_q) ? STATUS_SELF : STATUS_PRESENT;
            oslot_d = '0;
            othr_d  = '0;
            opc_d   = '0;
            olast_d = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          vis_d    = SLOT_COUNT'(1) << to_q;
          sp_d     = '0;
          push     = 1'b1;
          push_val = to_q;
          sp_d     = SP_W'(1);
          found_d  = 1'b0;
          adj_re   = 1'b1;
          adj_ra   = to_q;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!pick.hit) begin
          sp_d = sp_q - SP_W'(1);
          if (sp_q == SP_W'(1)) begin
            state_d = ST_WRITE;
          end else begin
            adj_re = 1'b1;
            adj_ra = stk_q[below_idx];
          end
        end else if (pick.idx == from_q) begin
          found_d = 1'b1;
          state_d = ST_WRITE;
        end else begin
          vis_d[pick.idx] = 1'b1;
          push     = 1'b1;
          push_val = pick.idx;
          sp_d     = sp_q + SP_W'(1);
          adj_re   = 1'b1;
          adj_ra   = pick.idx;
        end
      end
      ST_WRITE: begin
        adj_we  = 1'b1;
        edge_we = 1'b1;
        if (found_q) begin
          k_d     = '0;
          state_d = ST_EMIT_RD;
        end else if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = STATUS_ADDED;
          oslot_d = '0;
          othr_d  = '0;
          opc_d   = '0;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        edge_re = 1'b1;
        edge_ra = {stk_q[k_q], (k_q == top_idx) ? from_q : stk_q[k_q + SLOT_W'(1)]};
        state_d = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = STATUS_CYCLE;
          oslot_d = stk_q[k_q];
          othr_d  = edge_rdata_q[INFO_W-1 -: THR_W];
          opc_d   = edge_rdata_q[PC_W-1:0];
          olast_d = 1'b0;
          if (k_q == top_idx) begin
            state_d = ST_FINAL;
          end else begin
            k_d     = k_q + SLOT_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ostat_d = STATUS_CYCLE;
          oslot_d = from_q;
          othr_d  = thr_q;
          opc_d   = pc_q;
          olast_d = 1'b1;
          // empty the stack so the next search starts at the bottom
          sp_d    = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      found_q <= 1'b0;
      sp_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      found_q <= found_d;
      sp_q    <= sp_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    from_q     <= from_d;
    to_q       <= to_d;
    thr_q      <= thr_d;
    pc_q       <= pc_d;
    mask_q     <= mask_d;
    from_row_q <= from_row_d;
    vis_q      <= vis_d;
    ostat_q    <= ostat_d;
    oslot_q    <= oslot_d;
    othr_q     <= othr_d;
    opc_q      <= opc_d;
    olast_q    <= olast_d;
  end

  assign out_valid_o  = ov_q;
  assign status_o     = ostat_q;
  assign chain_slot_o = oslot_q;
  assign hop_thread_o = othr_q;
  assign hop_pc_o     = opc_q;
  assign last_o       = olast_q;

  // the search stack never grows past the slot count
  assert property (@(posedge clk_i) disable iff (!rst_ni) sp_q <= SP_W'(SLOT_COUNT))
    else $error("search stack overflow");

  // a search step always has a current slot on the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |-> sp_q != '0)
    else $error("scan with empty stack");

  // a new beat is only loaded while the output register is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(opc_q) && $stable(oslot_q))
    else $error("output beat overwritten");

  // a non-final result is always part of a cycle report
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !olast_q |-> ostat_q == STATUS_CYCLE)
    else $error("non-final beat without cycle");

endmodule
